// ===== sv/jfpc_pkg.sv =====
// Shared types, codes and helpers for the JPEG frame process checker.
package jfpc_pkg;

  localparam logic [7:0] BYTE_FILL = 8'hFF;
  localparam logic [7:0] CODE_SOI  = 8'hD8;
  localparam logic [7:0] CODE_SOS  = 8'hDA;
  localparam logic [7:0] CODE_EOI  = 8'hD9;
  localparam logic [7:0] CODE_TEM  = 8'h01;
  localparam logic [7:0] CODE_RST0 = 8'hD0;
  localparam logic [7:0] CODE_RST7 = 8'hD7;
  localparam logic [7:0] CODE_SOF0 = 8'hC0;
  localparam logic [7:0] CODE_SOF2 = 8'hC2;
  localparam logic [7:0] CODE_SOF_LAST = 8'hCF;
  localparam logic [7:0] CODE_DHT  = 8'hC4;
  localparam logic [7:0] CODE_JPG  = 8'hC8;
  localparam logic [7:0] CODE_DAC  = 8'hCC;

  typedef enum logic [2:0] {
    V_ACCEPTED    = 3'd0,
    V_BAD_SIG     = 3'd1,
    V_MALFORMED   = 3'd2,
    V_UNSUPPORTED = 3'd3,
    V_NO_FRAME    = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    PH_SIG0  = 3'd0,
    PH_SIG1  = 3'd1,
    PH_MARK  = 3'd2,
    PH_FILL  = 3'd3,
    PH_LENHI = 3'd4,
    PH_LENLO = 3'd5,
    PH_SKIP  = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  typedef struct packed {
    logic       valid;
    verdict_t   verdict;
    logic [7:0] code;
  } jfpc_result_t;

  typedef struct packed {
    phase_t       phase;
    jfpc_result_t result;
  } jfpc_status_t;

  // Start-of-frame codes: C0..CF apart from DHT, JPG and DAC.
  function automatic logic is_frame_code(input logic [7:0] c);
    logic in_range;
    in_range = (c >= CODE_SOF0) && (c <= CODE_SOF_LAST);
    return in_range && (c != CODE_DHT) && (c != CODE_JPG) && (c != CODE_DAC);
  endfunction

  function automatic logic is_standalone(input logic [7:0] c);
    return (c == CODE_TEM) || ((c >= CODE_RST0) && (c <= CODE_RST7));
  endfunction

endpackage

// ===== sv/jfpc_byte_if.sv =====
// Byte channel into the checker: one file byte and its last-byte flag.
interface jfpc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== sv/jfpc_result_if.sv =====
// Result channel out of the checker: verdict and start-of-frame code.
interface jfpc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic [7:0] frame_code;

  modport source (output valid, output verdict, output frame_code, input ready);
  modport sink   (input valid, input verdict, input frame_code, output ready);
endinterface

// ===== sv/jfpc_walker.sv =====
// Marker segment walker: phase, length and skip count, and the per-byte verdict.
module jfpc_walker
  import jfpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [7:0]   data_byte,
  input  logic         final_byte,
  output jfpc_status_t status
);

  phase_t       phase, phase_next;
  logic [15:0]  skip_left, skip_left_next;
  logic [7:0]   length_high, length_high_next;
  jfpc_result_t res;
  logic         active;
  logic [15:0]  seg_len;
  logic [15:0]  skip_dec;

  assign seg_len  = {length_high, data_byte};
  assign skip_dec = skip_left - {15'd0, (skip_left != 16'd0)};

  always_comb begin
    phase_next       = phase;
    skip_left_next   = skip_left;
    length_high_next = length_high;
    res.valid        = 1'b0;
    res.verdict      = V_NO_FRAME;
    res.code         = 8'd0;
    active           = 1'b1;

    unique case (phase)
      PH_SIG0: begin
        if (data_byte != BYTE_FILL || final_byte) begin
          res.valid   = 1'b1;
          res.verdict = V_BAD_SIG;
        end else begin
          phase_next = PH_SIG1;
        end
      end
      PH_SIG1: begin
        if (data_byte != CODE_SOI) begin
          res.valid   = 1'b1;
          res.verdict = V_BAD_SIG;
        end else begin
          phase_next = PH_MARK;
        end
      end
      PH_MARK: begin
        if (data_byte != BYTE_FILL) begin
          res.valid   = 1'b1;
          res.verdict = V_MALFORMED;
        end else begin
          phase_next = PH_FILL;
        end
      end
      PH_FILL: begin
        if (data_byte == BYTE_FILL) begin
          phase_next = PH_FILL;
        end else if (is_frame_code(data_byte)) begin
          res.valid   = 1'b1;
          res.verdict = (data_byte == CODE_SOF0 || data_byte == CODE_SOF2) ?
                        V_ACCEPTED : V_UNSUPPORTED;
          res.code    = data_byte;
        end else if (data_byte == CODE_SOS || data_byte == CODE_EOI) begin
          res.valid   = 1'b1;
          res.verdict = V_NO_FRAME;
        end else if (is_standalone(data_byte)) begin
          phase_next = PH_MARK;
        end else begin
          phase_next = PH_LENHI;
        end
      end
      PH_LENHI: begin
        length_high_next = data_byte;
        phase_next       = PH_LENLO;
      end
      PH_LENLO: begin
        if (seg_len < 16'd2) begin
          res.valid   = 1'b1;
          res.verdict = V_NO_FRAME;
        end else if (seg_len == 16'd2) begin
          phase_next = PH_MARK;
        end else begin
          skip_left_next = seg_len - 16'd2;
          phase_next     = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = PH_MARK;
      end
      PH_DONE: begin
        active = 1'b0;
      end
      default: begin
        active = 1'b0;
      end
    endcase

    // File ran out before anything decided it
    if (!res.valid && active && final_byte) begin
      res.valid   = 1'b1;
      res.verdict = V_NO_FRAME;
    end

    if (final_byte) begin
      phase_next       = PH_SIG0;
      skip_left_next   = 16'd0;
      length_high_next = 8'd0;
    end else if (res.valid) begin
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SIG0;
      skip_left   <= 16'd0;
      length_high <= 8'd0;
    end else if (fire) begin
      phase       <= phase_next;
      skip_left   <= skip_left_next;
      length_high <= length_high_next;
    end
  end

  assign status.phase  = phase;
  assign status.result = res;

endmodule

// ===== sv/jpeg_frame_process_checker.sv =====
// Top level of the JPEG frame process checker: walker plus result register.
//
//   channel  dir  payload                        accepted when
//   stream   in   data_byte[7:0], final_byte     valid && ready
//   result   out  verdict[2:0], frame_code[7:0]  valid && ready
//
// One byte per cycle; a byte is worked on in the cycle it is taken and any
// verdict lands in the result register on the same edge.
// Zero or one result per byte, at most one per file (plus none after it).
// Input is stalled only while the result register is full and not taken.
// rst is synchronous; afterwards the checker expects the first signature byte.
module jpeg_frame_process_checker
  import jfpc_pkg::*;
(
  input logic          clk,
  input logic          rst,
  jfpc_byte_if.sink    stream,
  jfpc_result_if.source result
);

  jfpc_status_t status;
  logic         in_fire;
  logic         out_valid;
  verdict_t     out_verdict;
  logic [7:0]   out_code;

  assign stream.ready = !out_valid || result.ready;
  assign in_fire      = stream.valid && stream.ready;

  jfpc_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .fire       (in_fire),
    .data_byte  (stream.data_byte),
    .final_byte (stream.final_byte),
    .status     (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && status.result.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && status.result.valid) begin
      out_verdict <= status.result.verdict;
      out_code    <= status.result.code;
    end
  end

  assign result.valid      = out_valid;
  assign result.verdict    = out_verdict;
  assign result.frame_code = out_code;

  // A last byte always sends the walker back to the signature check
  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    in_fire && stream.final_byte |=> status.phase == PH_SIG0)
    else $error("walker not back at signature after last byte");

  // Accepted only for baseline or progressive frames
  a_accept_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_verdict == V_ACCEPTED |->
      out_code == CODE_SOF0 || out_code == CODE_SOF2)
    else $error("accepted verdict with wrong frame code");

  // Verdicts that found no frame carry no code
  a_no_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_verdict == V_BAD_SIG || out_verdict == V_MALFORMED ||
                  out_verdict == V_NO_FRAME) |-> out_code == 8'd0)
    else $error("frame code set on a verdict without a frame");

  // Once a verdict is out, the rest of the file gives nothing
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    status.phase == PH_DONE |-> !status.result.valid)
    else $error("second verdict in one file");

endmodule

// ===== verif/jpeg_frame_process_checker_tb.sv =====
// Self-checking testbench for the JPEG frame process checker: file streams in, verdicts out.
module jpeg_frame_process_checker_tb;
  import jfpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int RANDOM_BYTES = 750;
  localparam int HOLD_AT      = 800;
  localparam int HOLD_LEN     = 400;

  // Marker codes used only by the stimulus
  localparam logic [7:0] CODE_APP0     = 8'hE0;
  localparam logic [7:0] CODE_DQT      = 8'hDB;
  localparam logic [7:0] CODE_COM      = 8'hFE;
  localparam logic [7:0] CODE_RESV_LOW = 8'h02;
  localparam logic [7:0] CODE_RESV_TOP = 8'hBF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hold;
  } file_byte_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [7:0] code;
  } verdict_item_t;

  logic clk = 1'b0;
  logic rst;

  jfpc_byte_if   stream_if ();
  jfpc_result_if result_if ();

  jpeg_frame_process_checker uut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  always #5 clk = ~clk;

  file_byte_t    byte_q[$];
  verdict_item_t verdict_q[$];
  logic [7:0]    file_buf[$];

  int errors;
  int files_built;
  int bytes_taken;
  int verdicts_seen;
  int verdict_tally[5];

  // Predictor state of the marker walker
  phase_t      walk_phase;
  logic [15:0] body_left;
  logic [7:0]  len_msb;

  task automatic walk_reset();
    walk_phase = PH_SIG0;
    body_left  = '0;
    len_msb    = '0;
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic last);
    logic          hit;
    logic          busy;
    logic          sof;
    logic [15:0]   seg_len;
    verdict_item_t v;
    hit  = 1'b0;
    busy = 1'b1;
    v.verdict = V_ACCEPTED;
    v.code    = '0;
    // C0..CF, leaving out C4, C8 and CC
    sof = (b[7:4] == 4'hC) && ((b[1:0] != 2'b00) || (b[3:2] == 2'b00));
    case (walk_phase)
      PH_SIG0: begin
        if (b != BYTE_FILL || last) begin
          hit = 1'b1;
          v.verdict = V_BAD_SIG;
        end else begin
          walk_phase = PH_SIG1;
        end
      end
      PH_SIG1: begin
        if (b != CODE_SOI) begin
          hit = 1'b1;
          v.verdict = V_BAD_SIG;
        end else begin
          walk_phase = PH_MARK;
        end
      end
      PH_MARK: begin
        if (b != BYTE_FILL) begin
          hit = 1'b1;
          v.verdict = V_MALFORMED;
        end else begin
          walk_phase = PH_FILL;
        end
      end
      PH_FILL: begin
        if (b == BYTE_FILL) begin
          walk_phase = PH_FILL;
        end else if (sof) begin
          hit = 1'b1;
          v.code = b;
          v.verdict = (b == CODE_SOF0 || b == CODE_SOF2) ? V_ACCEPTED : V_UNSUPPORTED;
        end else if (b == CODE_SOS || b == CODE_EOI) begin
          hit = 1'b1;
          v.verdict = V_NO_FRAME;
        end else if (b == CODE_TEM || (b >= CODE_RST0 && b <= CODE_RST7)) begin
          walk_phase = PH_MARK;
        end else begin
          walk_phase = PH_LENHI;
        end
      end
      PH_LENHI: begin
        len_msb = b;
        walk_phase = PH_LENLO;
      end
      PH_LENLO: begin
        seg_len = {len_msb, b};
        if (seg_len < 16'd2) begin
          hit = 1'b1;
          v.verdict = V_NO_FRAME;
        end else if (seg_len == 16'd2) begin
          walk_phase = PH_MARK;
        end else begin
          body_left = seg_len - 16'd2;
          walk_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (body_left != '0) body_left = body_left - 16'd1;
        if (body_left == '0) walk_phase = PH_MARK;
      end
      default: busy = 1'b0;
    endcase
    // file ran out before anything decided
    if (!hit && busy && last) begin
      hit = 1'b1;
      v.verdict = V_NO_FRAME;
    end
    if (hit) verdict_q.push_back(v);
    if (last) walk_reset();
    else if (hit) walk_phase = PH_DONE;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_file(input logic hold);
    file_byte_t fb;
    for (int i = 0; i < file_buf.size(); i++) begin
      fb.data = file_buf[i];
      fb.last = (i == file_buf.size() - 1);
      fb.hold = hold && (i == 0);
      byte_q.push_back(fb);
    end
    files_built++;
  endtask

  task automatic add_fill();
    file_buf.push_back(BYTE_FILL);
    if ($urandom_range(0, 99) < 25)
      repeat ($urandom_range(1, 3)) file_buf.push_back(BYTE_FILL);
  endtask

  // Random file: mostly well-formed segment chains, some cut short, mangled or noise
  task automatic make_file();
    int         kind;
    int         nseg;
    int         r;
    int         body;
    int         cut;
    logic       stop;
    logic [7:0] code;
    file_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      repeat ($urandom_range(1, 6))
        file_buf.push_back($urandom_range(0, 1) ? BYTE_FILL : 8'($urandom));
      return;
    end
    file_buf.push_back(BYTE_FILL);
    file_buf.push_back(CODE_SOI);
    nseg = $urandom_range(0, 3);
    stop = 1'b0;
    for (int s = 0; s < nseg && !stop; s++) begin
      add_fill();
      r = $urandom_range(0, 99);
      if (r < 20) begin
        code = ($urandom_range(0, 8) == 8) ? CODE_TEM : CODE_RST0 + 8'($urandom_range(0, 7));
        file_buf.push_back(code);
      end else if (r < 25) begin
        file_buf.push_back($urandom_range(0, 1) ? CODE_SOS : CODE_EOI);
        stop = 1'b1;
      end else begin
        case ($urandom_range(0, 5))
          0: code = CODE_APP0 + 8'($urandom_range(0, 15));
          1: code = CODE_DQT;
          2: code = CODE_DHT;
          3: code = $urandom_range(0, 1) ? CODE_JPG : CODE_DAC;
          4: code = CODE_COM;
          default: code = 8'($urandom_range(CODE_RESV_LOW, CODE_RESV_TOP));
        endcase
        file_buf.push_back(code);
        r = $urandom_range(0, 99);
        if (r < 6) begin
          file_buf.push_back(8'h00);
          file_buf.push_back(8'($urandom_range(0, 1)));
          stop = 1'b1;
        end else if (r < 14) begin
          // long segment: the file stops inside its body
          file_buf.push_back(8'($urandom_range(1, 255)));
          file_buf.push_back(8'($urandom));
          repeat ($urandom_range(0, 4)) file_buf.push_back(8'($urandom));
          stop = 1'b1;
        end else begin
          body = $urandom_range(2, 9);
          file_buf.push_back(8'h00);
          file_buf.push_back(8'(body));
          repeat (body - 2) file_buf.push_back(8'($urandom));
        end
      end
    end
    if (!stop) begin
      add_fill();
      r = $urandom_range(0, 99);
      if (r < 40) code = CODE_SOF0;
      else if (r < 70) code = CODE_SOF2;
      else code = CODE_SOF0 + 8'($urandom_range(0, 15));
      file_buf.push_back(code);
    end
    repeat ($urandom_range(0, 4))
      file_buf.push_back(($urandom_range(0, 3) == 0) ? BYTE_FILL : 8'($urandom));
    if (kind >= 70 && kind < 85) begin
      cut = $urandom_range(1, file_buf.size());
      while (file_buf.size() > cut) void'(file_buf.pop_back());
    end else if (kind >= 85) begin
      file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom);
    end
  endtask

  // Sender
  int tx_gap;
  int tx_calm;

  always @(posedge clk) begin
    file_byte_t fb;
    if (rst) begin
      stream_if.valid <= 1'b0;
      tx_gap  = 0;
      tx_calm = 0;
    end else if (!stream_if.valid || stream_if.ready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        stream_if.valid <= 1'b0;
      end else if (byte_q.size() == 0) begin
        stream_if.valid <= 1'b0;
      end else if (byte_q[0].hold &&
                   (stream_if.valid || result_if.valid || verdict_q.size() != 0)) begin
        // wait for every pending verdict before this file starts
        stream_if.valid <= 1'b0;
      end else begin
        fb = byte_q.pop_front();
        stream_if.valid      <= 1'b1;
        stream_if.data_byte  <= fb.data;
        stream_if.final_byte <= fb.last;
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else if ($urandom_range(0, 99) < 3) begin
          tx_calm = $urandom_range(20, 80);
          tx_gap  = 0;
        end else begin
          tx_gap = idle_len();
        end
      end
    end
  end

  // Receiver
  int rx_stall;
  int rx_calm;
  int rx_cycles;

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      rx_stall  = 0;
      rx_calm   = 0;
      rx_cycles = 0;
    end else begin
      rx_cycles++;
      if (rx_cycles == HOLD_AT) rx_stall = HOLD_LEN;
      if (rx_stall > 0) begin
        rx_stall--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (rx_calm > 0) rx_calm--;
        else if ($urandom_range(0, 99) < 3) rx_calm = $urandom_range(30, 120);
        else if ($urandom_range(0, 3) == 0) rx_stall = idle_len();
      end
    end
  end

  // Monitor: check outgoing verdicts, then predict from the byte taken at this edge
  always @(posedge clk) begin
    verdict_item_t want;
    if (rst) begin
      walk_reset();
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got verdict %0d code %02h",
                   $time, result_if.verdict, result_if.frame_code);
        end else begin
          want = verdict_q.pop_front();
          verdicts_seen++;
          verdict_tally[want.verdict]++;
          if (result_if.verdict !== want.verdict) begin
            errors++;
            $display("%0t: verdict mismatch: expected %0d, got %0d",
                     $time, want.verdict, result_if.verdict);
          end
          if (result_if.frame_code !== want.code) begin
            errors++;
            $display("%0t: frame_code mismatch: expected %02h, got %02h",
                     $time, want.code, result_if.frame_code);
          end
        end
      end
      if (stream_if.valid && stream_if.ready) begin
        walk_byte(stream_if.data_byte, stream_if.final_byte);
        bytes_taken++;
      end
    end
  end

  initial begin : watchdog
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int queued;
    int n;
    rst = 1'b1;
    stream_if.valid      = 1'b0;
    stream_if.data_byte  = '0;
    stream_if.final_byte = 1'b0;
    result_if.ready      = 1'b0;
    errors = 0;
    files_built = 0;
    bytes_taken = 0;
    verdicts_seen = 0;
    foreach (verdict_tally[i]) verdict_tally[i] = 0;

    // one-byte file
    file_buf = '{BYTE_FILL};
    push_file(1'b0);
    // non-FF where a marker should start; the final byte after it gives nothing
    file_buf = '{BYTE_FILL, CODE_SOI, 8'h7E, BYTE_FILL};
    push_file(1'b0);
    // restart marker, then SOS before any frame, verdict on the final byte
    file_buf = '{BYTE_FILL, CODE_SOI, BYTE_FILL, CODE_RST7, BYTE_FILL, CODE_SOS};
    push_file(1'b0);
    // segment length under two
    file_buf = '{BYTE_FILL, CODE_SOI, BYTE_FILL, CODE_APP0, 8'h00, 8'h01};
    push_file(1'b0);
    // body skipped, fill run, last frame code
    file_buf = '{BYTE_FILL, CODE_SOI, BYTE_FILL, CODE_DQT, 8'h00, 8'h03, 8'h5A,
                 BYTE_FILL, BYTE_FILL, CODE_SOF_LAST};
    push_file(1'b0);

    queued = 0;
    while (queued < RANDOM_BYTES) begin
      make_file();
      queued += file_buf.size();
      push_file(files_built == 5 || files_built == 30);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || stream_if.valid) @(posedge clk);
    n = 0;
    while (verdict_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      errors++;
      $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
    end

    $display("Covered %0d bytes in %0d files, %0d verdicts checked, %0d mismatches",
             bytes_taken, files_built, verdicts_seen, errors);
    $display("Verdicts: accepted %0d, bad sig %0d, malformed %0d, unsupported %0d, no frame %0d",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
             verdict_tally[4]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
